### src/nfcs_pkg.sv
// Shared types, constants and the command operation table of the NOR flash
// command sequencer. No dependencies.
`timescale 1ns / 1ps

package nfcs_pkg;

  localparam int unsigned AddrW = 19;
  localparam int unsigned DataW = 8;
  localparam int unsigned WaitW = 20;
  localparam int unsigned OpIdxW = 3;
  localparam int unsigned SubW = 2;

  typedef enum logic [2:0] {
    KIND_READ      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_PROGRAM   = 3'd2,
    KIND_SECTOR_ER = 3'd3,
    KIND_CHIP_ER   = 3'd4,
    KIND_READ_ID   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_PROGRAM_WAIT = 2'd0,
    REG_SECTOR_WAIT  = 2'd1,
    REG_CHIP_WAIT    = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ADDR_INPUT,
    ADDR_UNLOCK1,
    ADDR_UNLOCK2,
    ADDR_ZERO,
    ADDR_ONE
  } addr_sel_e;

  localparam logic [AddrW-1:0] Unlock1Addr = AddrW'(20'h05555);
  localparam logic [AddrW-1:0] Unlock2Addr = AddrW'(20'h02aaa);
  localparam logic [DataW-1:0] Unlock1Data = 8'haa;
  localparam logic [DataW-1:0] Unlock2Data = 8'h55;
  localparam logic [DataW-1:0] CmdReadId = 8'h90;
  localparam logic [DataW-1:0] CmdProgram = 8'ha0;
  localparam logic [DataW-1:0] CmdEraseSetup = 8'h80;
  localparam logic [DataW-1:0] CmdSectorErase = 8'h30;
  localparam logic [DataW-1:0] CmdChipErase = 8'h10;
  localparam logic [DataW-1:0] CmdReset = 8'hf0;

  // One queued command, already classified by the front end.
  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  address;
    logic [DataW-1:0]  data;
    logic              burst_end;
    logic [WaitW-1:0]  wait_us;
  } cmd_t;

  // One bus operation: a byte write (up to 4 steps) or a byte read (up to 2).
  typedef struct packed {
    logic             is_read;
    addr_sel_e        addr_sel;
    logic             use_in_data;
    logic [DataW-1:0] data;
    logic             final_op;
  } op_t;

  // One pin-level bus step.
  typedef struct packed {
    logic [WaitW-1:0] wait_us;
    logic             sample_data;
    logic             write_enable_n;
    logic             output_enable_n;
    logic             chip_enable_n;
    logic             drive_data;
    logic [DataW-1:0] data_out;
    logic [AddrW-1:0] bus_address;
  } step_t;

  function automatic op_t mk_write(addr_sel_e sel, logic [DataW-1:0] data,
                                   logic use_in, logic fin);
    op_t op;
    op.is_read = 1'b0;
    op.addr_sel = sel;
    op.use_in_data = use_in;
    op.data = data;
    op.final_op = fin;
    return op;
  endfunction

  function automatic op_t mk_read(addr_sel_e sel, logic fin);
    op_t op;
    op.is_read = 1'b1;
    op.addr_sel = sel;
    op.use_in_data = 1'b0;
    op.data = '0;
    op.final_op = fin;
    return op;
  endfunction

  // Operation number idx of a command of the given kind.
  function automatic op_t op_lookup(kind_e kind, logic [OpIdxW-1:0] idx);
    op_t op;
    op = mk_write(ADDR_UNLOCK1, Unlock1Data, 1'b0, 1'b0);
    unique case (kind)
      KIND_READ: op = mk_read(ADDR_INPUT, 1'b1);
      KIND_WRITE: op = mk_write(ADDR_INPUT, '0, 1'b1, 1'b1);
      KIND_PROGRAM: begin
        case (idx)
          3'd0: op = mk_write(ADDR_UNLOCK1, Unlock1Data, 1'b0, 1'b0);
          3'd1: op = mk_write(ADDR_UNLOCK2, Unlock2Data, 1'b0, 1'b0);
          3'd2: op = mk_write(ADDR_UNLOCK1, CmdProgram, 1'b0, 1'b0);
          default: op = mk_write(ADDR_INPUT, '0, 1'b1, 1'b1);
        endcase
      end
      KIND_SECTOR_ER, KIND_CHIP_ER: begin
        case (idx)
          3'd0, 3'd3: op = mk_write(ADDR_UNLOCK1, Unlock1Data, 1'b0, 1'b0);
          3'd1, 3'd4: op = mk_write(ADDR_UNLOCK2, Unlock2Data, 1'b0, 1'b0);
          3'd2: op = mk_write(ADDR_UNLOCK1, CmdEraseSetup, 1'b0, 1'b0);
          default: begin
            if (kind == KIND_SECTOR_ER) begin
              op = mk_write(ADDR_INPUT, CmdSectorErase, 1'b0, 1'b1);
            end else begin
              op = mk_write(ADDR_UNLOCK1, CmdChipErase, 1'b0, 1'b1);
            end
          end
        endcase
      end
      KIND_READ_ID: begin
        case (idx)
          3'd0: op = mk_write(ADDR_UNLOCK1, Unlock1Data, 1'b0, 1'b0);
          3'd1: op = mk_write(ADDR_UNLOCK2, Unlock2Data, 1'b0, 1'b0);
          3'd2: op = mk_write(ADDR_UNLOCK1, CmdReadId, 1'b0, 1'b0);
          3'd3: op = mk_read(ADDR_ZERO, 1'b0);
          3'd4: op = mk_read(ADDR_ONE, 1'b0);
          default: op = mk_write(ADDR_ZERO, CmdReset, 1'b0, 1'b1);
        endcase
      end
      default: op = mk_write(ADDR_UNLOCK1, Unlock1Data, 1'b0, 1'b1);
    endcase
    return op;
  endfunction

endpackage

### src/nfcs_front.sv
// Front end of the NOR flash command sequencer: wait-time registers and
// command classification into the queue. Depends on nfcs_pkg.
`timescale 1ns / 1ps

module nfcs_front #(
  parameter int unsigned ADDRESS_BITS = 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,
  input  logic [2:0]                  s_axis_tuser,
  input  logic                        s_axis_tlast,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [nfcs_pkg::WaitW-1:0]  cfg_data_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output nfcs_pkg::cmd_t              q_cmd_o
);
  import nfcs_pkg::*;

  localparam int unsigned KeepBits = (ADDRESS_BITS < AddrW) ? ADDRESS_BITS : AddrW;
  localparam logic [AddrW-1:0] AddrMask = AddrW'((64'd1 << KeepBits) - 64'd1);

  logic [WaitW-1:0] program_wait_q;
  logic [WaitW-1:0] sector_wait_q;
  logic [WaitW-1:0] chip_wait_q;
  logic             known_kind;
  logic [WaitW-1:0] wait_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_wait_q <= WaitW'(20);
      sector_wait_q  <= WaitW'(25000);
      chip_wait_q    <= WaitW'(100000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PROGRAM_WAIT: program_wait_q <= cfg_data_i;
        REG_SECTOR_WAIT:  sector_wait_q <= cfg_data_i;
        REG_CHIP_WAIT:    chip_wait_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Codes above read id expand to nothing and are dropped here.
  assign known_kind = (s_axis_tuser <= 3'(KIND_READ_ID));

  always_comb begin
    case (s_axis_tuser)
      KIND_PROGRAM:   wait_sel = program_wait_q;
      KIND_SECTOR_ER: wait_sel = sector_wait_q;
      KIND_CHIP_ER:   wait_sel = chip_wait_q;
      default:        wait_sel = '0;
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o = s_axis_tvalid && !q_full_i && known_kind;

  always_comb begin
    q_cmd_o.kind = kind_e'(s_axis_tuser);
    q_cmd_o.address = s_axis_tdata[AddrW-1:0] & AddrMask;
    q_cmd_o.data = s_axis_tdata[AddrW+DataW-1:AddrW];
    q_cmd_o.burst_end = s_axis_tlast;
    q_cmd_o.wait_us = wait_sel;
  end

endmodule

### src/nfcs_fifo.sv
// Two-entry command queue between the front end and the bus sequencer.
// Depends on nfcs_pkg.
`timescale 1ns / 1ps

module nfcs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nfcs_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nfcs_pkg::cmd_t pop_cmd_o
);
  import nfcs_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign full_o = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

endmodule

### src/nfcs_back.sv
// Bus sequencer of the NOR flash command sequencer: walks the operations of one
// command into an output register, one step per unstalled cycle. Needs nfcs_pkg.
`timescale 1ns / 1ps

module nfcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  nfcs_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output nfcs_pkg::step_t m_step_o,
  output logic           m_last_o
);
  import nfcs_pkg::*;

  logic              busy_q;
  cmd_t              cmd_q;
  logic [OpIdxW-1:0] op_q;
  logic [SubW-1:0]   sub_q;
  logic              out_valid_q;
  step_t             out_q;
  logic              out_last_q;

  op_t               op;
  logic              release_step;
  logic [SubW-1:0]   last_sub;
  logic              op_done;
  logic              step_last;
  logic              emit;
  logic [AddrW-1:0]  addr;
  logic [DataW-1:0]  byte_val;
  step_t             step;

  always_comb begin
    op = op_lookup(cmd_q.kind, op_q);
    // Read and raw write bursts only release the bus on the burst's last byte.
    if (cmd_q.kind == KIND_READ || cmd_q.kind == KIND_WRITE) begin
      release_step = cmd_q.burst_end;
    end else begin
      release_step = 1'b1;
    end
    if (op.is_read) begin
      last_sub = release_step ? 2'd1 : 2'd0;
    end else begin
      last_sub = release_step ? 2'd3 : 2'd2;
    end
    op_done = (sub_q == last_sub);
    step_last = op_done && op.final_op;

    case (op.addr_sel)
      ADDR_INPUT:   addr = cmd_q.address;
      ADDR_UNLOCK1: addr = Unlock1Addr;
      ADDR_UNLOCK2: addr = Unlock2Addr;
      ADDR_ONE:     addr = AddrW'(1);
      default:      addr = '0;
    endcase
    byte_val = op.use_in_data ? cmd_q.data : op.data;

    step.bus_address = addr;
    step.data_out = '0;
    step.drive_data = 1'b0;
    step.chip_enable_n = 1'b1;
    step.output_enable_n = 1'b1;
    step.write_enable_n = 1'b1;
    step.sample_data = 1'b0;
    step.wait_us = step_last ? cmd_q.wait_us : '0;
    if (op.is_read) begin
      if (sub_q == 2'd0) begin
        step.chip_enable_n = 1'b0;
        step.output_enable_n = 1'b0;
        step.sample_data = 1'b1;
      end
    end else if (sub_q != 2'd3) begin
      step.data_out = byte_val;
      step.drive_data = 1'b1;
      step.chip_enable_n = 1'b0;
      step.write_enable_n = (sub_q != 2'd1);
    end
  end

  assign emit = busy_q && (!out_valid_q || m_ready_i);
  assign q_pop_o = q_valid_i && (!busy_q || (emit && step_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q <= '0;
      sub_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        op_q <= '0;
        sub_q <= '0;
      end else if (emit) begin
        if (step_last) begin
          busy_q <= 1'b0;
        end
        if (op_done) begin
          op_q <= op_q + 3'd1;
          sub_q <= '0;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (emit) begin
      out_q <= step;
      out_last_q <= step_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_step_o = out_q;
  assign m_last_o = out_last_q;

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("command popped from an empty queue");

  a_read_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && op.is_read |-> sub_q <= 2'd1)
    else $error("read operation ran past its release step");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> op_q <= 3'd5)
    else $error("operation index ran past the longest command");

  a_wait_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !step_last |=> out_q.wait_us == '0 && !out_last_q)
    else $error("wait time or last flag on an inner bus step");

endmodule

### src/nor_flash_command_sequencer.sv
// Top level of the parallel NOR flash command sequencer: front end, command
// queue and bus sequencer. Depends on nfcs_pkg, nfcs_front, nfcs_fifo, nfcs_back.
`timescale 1ns / 1ps

// Each request on the slave stream is one flash command (read byte, raw write
// byte, program byte, sector erase, chip erase or read id), and the block
// answers with the pin-level bus steps of that command on the master stream,
// one step per transfer, with tlast on the command's final step. Program and
// erase commands start with the unlock writes 0x5555/0xAA and 0x2AAA/0x55,
// and their final step carries the wait time from the matching register.
// Read steps raise sample_data so the host captures the data bus. In read and
// raw write bursts the release step comes only when the request's tlast is
// set. Kind codes 6 and 7 are accepted and produce no steps. A command has
// 1 or 2 bus steps for a read, 3 or 4 for a raw write, 16 for a program,
// 20 for a read id and 24 for an erase; the bus sequencer emits exactly one
// step per cycle while the output is not stalled. A two-entry queue sits
// between the request side and the sequencer, so new requests are taken while
// an earlier command is still being expanded, and the next command is taken
// from the queue in the same cycle as the previous one's last step is emitted.
// The wait-time registers may only be written while no command is in flight.
module nor_flash_command_sequencer #(
  parameter int unsigned ADDRESS_BITS = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [18:0] address, [26:19] data, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser,
  // burst_end
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [18:0] bus_address, [26:19] data_out, [27] drive_data, [28] chip_enable_n,
  // [29] output_enable_n, [30] write_enable_n, [31] sample_data,
  // [51:32] wait_us, [55:52] zero
  output logic [55:0] m_axis_tdata,
  // last
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import nfcs_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  cmd_t  push_cmd;
  cmd_t  pop_cmd;
  step_t m_step;

  nfcs_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  nfcs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  nfcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_step_o  (m_step),
    .m_last_o  (m_axis_tlast)
  );

  // The step struct is already packed in stream order, bus_address in the lowest bits.
  assign m_axis_tdata = {4'b0000, m_step};

endmodule
